### src/tvp_pkg.sv
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared constants and helpers for the trapezoidal velocity profile.
// ----------------------------------------------------------------------------
package tvp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL = 3'd0,
    REG_PEAK  = 3'd1,
    REG_START = 3'd2,
    REG_END   = 3'd3,
    REG_LEN   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2
  } phase_t;

  // saturate a wide signed value to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] res;
    if ((&v[67:31]) || !(|v[67:31])) begin
      res = v[31:0];
    end else if (v[67]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

### src/tvp_div.sv
// ----------------------------------------------------------------------------
// tvp_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero,
// quotient saturated to 32 bit signed.
// ----------------------------------------------------------------------------
module tvp_div
  import tvp_pkg::*;
#(
  parameter int NW = 32 + FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW:0]   num,
  input  logic        [30:0]   den,
  output logic                 done,
  output logic signed [31:0]   quo
);

  localparam int CW = $clog2(NW);

  logic                run_r, run_nxt;
  logic                fix_r, fix_nxt;
  logic                done_r, done_nxt;
  logic                neg_r;
  logic [CW-1:0]       cnt_r;
  logic [NW-1:0]       dvd_r;
  logic [30:0]         rem_r;
  logic [30:0]         den_r;
  logic signed [31:0]  quo_r;

  logic [NW:0]         mag;
  logic [31:0]         trial;
  logic                qbit;
  logic [31:0]         diff;
  logic signed [67:0]  qext;

  assign mag   = num[NW] ? (NW+1)'(0) - num : num;
  assign trial = {rem_r, dvd_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r});
  assign qext  = neg_r ? 68'sd0 - $signed({{(68-NW){1'b0}}, dvd_r})
                       : $signed({{(68-NW){1'b0}}, dvd_r});

  always_comb begin
    run_nxt  = run_r;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    if (start) begin
      run_nxt = 1'b1;
    end else if (run_r && (cnt_r == CW'(NW - 1))) begin
      run_nxt = 1'b0;
      fix_nxt = 1'b1;
    end else if (fix_r) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
      if (start) begin
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NW];
      dvd_r <= mag[NW-1:0];
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= qbit ? diff[30:0] : trial[30:0];
      dvd_r <= {dvd_r[NW-2:0], qbit};
    end
    if (fix_r) begin
      quo_r <= sat32(qext);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### src/trapezoidal_velocity_profile.sv
// ----------------------------------------------------------------------------
// trapezoidal_velocity_profile
// Each time sample request gives the commanded speed, phase, total segment
// time and a negative-cruise flag. Samples flow through a five stage
// pipeline, one per cycle; a stall on the output holds the whole pipeline.
// A write to a defined register starts a recompute of the phase durations
// in a shared serial divider (three divisions of 32+FRAC_BITS steps plus
// two multiply legs); in_tready stays low until it finishes.
// ----------------------------------------------------------------------------
module trapezoidal_velocity_profile
  import tvp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // time_now[31:0], time_begin[63:32]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [71:0]          out_tdata,  // speed_cmd[31:0], phase[33:32],
                                           // total_time[65:34], no_cruise[66]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int NW = 32 + FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_WAIT, S_MUL, S_ACC, S_CSUB, S_CDIV, S_CWAIT, S_FIN
  } seq_t;

  // configuration
  logic [30:0]        accel_r, peak_r;
  logic signed [31:0] start_r, end_r, len_r;
  logic               cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == REG_ACCEL || cfg_index == REG_PEAK ||
                   cfg_index == REG_START || cfg_index == REG_END ||
                   cfg_index == REG_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= 31'(1) << FRAC_BITS;
      peak_r  <= 31'(5) << (FRAC_BITS - 1);
      start_r <= '0;
      end_r   <= '0;
      len_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL: accel_r <= cfg_data[30:0];
        REG_PEAK:  peak_r  <= cfg_data[30:0];
        REG_START: start_r <= cfg_data;
        REG_END:   end_r   <= cfg_data;
        REG_LEN:   len_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [30:0] a_eff, v_eff;
  assign a_eff = (accel_r == '0) ? 31'd1 : accel_r;
  assign v_eff = (peak_r == '0) ? 31'd1 : peak_r;

  // duration sequencer
  seq_t               st_r;
  logic               side_r;
  logic signed [31:0] up_r, dn_r, cr_r, dist_up_r, cdist_r;
  logic signed [48:0] pph_r;
  logic signed [49:0] ppl_r;
  logic signed [32:0] rc_r;
  logic signed [33:0] total_r;
  logic signed [31:0] total_sat_r;
  logic               nocr_r;

  logic               div_start, div_done;
  logic signed [NW:0] div_num;
  logic [30:0]        div_den;
  logic signed [31:0] div_quo;

  logic signed [32:0] leg_diff, leg_sum, cdist_ext;
  logic signed [31:0] leg_dur;
  logic signed [67:0] leg_prod, leg_shift;
  logic signed [33:0] dist_sum, cdist_full;
  logic signed [32:0] fin_rc;
  logic signed [33:0] fin_tot;

  assign leg_diff  = $signed({2'b00, v_eff}) - (side_r ? end_r : start_r);
  assign leg_sum   = $signed({2'b00, v_eff}) + (side_r ? end_r : start_r);
  assign leg_dur   = side_r ? dn_r : up_r;
  assign cdist_ext = 33'(cdist_r);
  assign div_start = (st_r == S_DIV) || (st_r == S_CDIV);
  assign div_num   = (st_r == S_CDIV) ? $signed({cdist_ext, {FRAC_BITS{1'b0}}})
                                      : $signed({leg_diff, {FRAC_BITS{1'b0}}});
  assign div_den   = (st_r == S_CDIV) ? v_eff : a_eff;
  assign leg_prod  = (68'(pph_r) <<< 16) + 68'(ppl_r);
  assign leg_shift = leg_prod >>> (FRAC_BITS + 1);
  assign dist_sum  = 34'(dist_up_r) + 34'(sat32(leg_shift));
  assign cdist_full = 34'(len_r) - dist_sum;
  assign fin_rc    = 33'(up_r) + 33'(cr_r);
  assign fin_tot   = 34'(fin_rc) + 34'(dn_r);

  tvp_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      side_r      <= 1'b0;
      up_r        <= '0;
      dn_r        <= '0;
      cr_r        <= '0;
      rc_r        <= '0;
      total_r     <= '0;
      total_sat_r <= '0;
      nocr_r      <= 1'b0;
    end else if (cfg_hit) begin
      st_r   <= S_DIV;
      side_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: ;
        S_DIV:  st_r <= S_WAIT;
        S_WAIT: begin
          if (div_done) begin
            if (side_r) dn_r <= div_quo;
            else        up_r <= div_quo;
            st_r <= S_MUL;
          end
        end
        S_MUL: begin
          pph_r <= leg_sum * $signed(leg_dur[31:16]);
          ppl_r <= leg_sum * $signed({1'b0, leg_dur[15:0]});
          st_r  <= S_ACC;
        end
        S_ACC: begin
          if (side_r) begin
            st_r <= S_CSUB;
          end else begin
            dist_up_r <= sat32(leg_shift);
            side_r    <= 1'b1;
            st_r      <= S_DIV;
          end
        end
        S_CSUB: begin
          cdist_r <= sat32(68'(cdist_full));
          st_r    <= S_CDIV;
        end
        S_CDIV: st_r <= S_CWAIT;
        S_CWAIT: begin
          if (div_done) begin
            cr_r <= div_quo;
            st_r <= S_FIN;
          end
        end
        S_FIN: begin
          rc_r        <= fin_rc;
          total_r     <= fin_tot;
          total_sat_r <= sat32(68'(fin_tot));
          nocr_r      <= cr_r[31];
          st_r        <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // sample pipeline
  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [32:0] e1_r;
  logic signed [34:0] x2_r;
  logic signed [31:0] b2_r, b3_r, b4_r;
  phase_t             p2_r, p3_r, p4_r, p5_r;
  logic signed [49:0] mh3_r;
  logic signed [48:0] ml3_r;
  logic signed [66:0] q4_r;
  logic signed [31:0] spd5_r;

  logic signed [32:0] e_in;
  logic signed [34:0] e_ext, tot_ext;
  logic signed [31:0] a_s;
  logic signed [66:0] psum;
  logic signed [67:0] spd_full;

  assign adv       = !v5_r || out_tready;
  assign in_tready = adv && (st_r == S_IDLE);
  assign e_in      = 33'($signed(in_tdata[31:0])) - 33'($signed(in_tdata[63:32]));
  assign e_ext     = 35'(e1_r);
  assign tot_ext   = 35'(total_r);
  assign a_s       = $signed({1'b0, a_eff});
  assign psum      = (67'(mh3_r) <<< 17) + 67'(ml3_r);
  assign spd_full  = 68'(b4_r) + 68'(q4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid && in_tready;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r <= e_in;
      priority if (e1_r < 33'(up_r)) begin
        p2_r <= PH_ACCEL;
        x2_r <= e_ext;
        b2_r <= start_r;
      end else if (e1_r > rc_r) begin
        p2_r <= PH_DECEL;
        x2_r <= tot_ext - e_ext;
        b2_r <= end_r;
      end else begin
        p2_r <= PH_CRUISE;
        x2_r <= '0;
        b2_r <= $signed({1'b0, v_eff});
      end
      mh3_r  <= a_s * $signed(x2_r[34:17]);
      ml3_r  <= a_s * $signed({1'b0, x2_r[16:0]});
      p3_r   <= p2_r;
      b3_r   <= b2_r;
      q4_r   <= psum >>> FRAC_BITS;
      p4_r   <= p3_r;
      b4_r   <= b3_r;
      spd5_r <= sat32(spd_full);
      p5_r   <= p4_r;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {5'd0, nocr_r, total_sat_r, p5_r, spd5_r};

endmodule

### src/tvp_checker.sv
// ----------------------------------------------------------------------------
// tvp_checker
// Port-level checks for the trapezoidal velocity profile.
// ----------------------------------------------------------------------------
module tvp_checker
  import tvp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        cfg_we,
  input logic [2:0]  cfg_index
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // recompute blocks sample requests
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cfg_we && (cfg_index <= REG_LEN) |=> !in_tready)
    else $error("request accepted during recompute");

  // phase code is valid
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:32] != 2'd3)
    else $error("bad phase code");

  // no result in the cycle after reset
  a_lat: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result right after reset");

endmodule

bind trapezoidal_velocity_profile tvp_checker u_tvp_checker (.*);

### test/trapezoidal_velocity_profile_tb.sv
// ----------------------------------------------------------------------------
// trapezoidal_velocity_profile_tb
// Drives time-sample requests through the profile block under several
// register settings and handshake idle mixes. A scoreboard predicts each
// sample from its own copy of the registers and phase durations, and
// compares speed, phase, total time and the no-cruise flag in order.
// ----------------------------------------------------------------------------
typedef struct {
  logic signed [31:0] speed;
  tvp_pkg::phase_t    ph;
  logic signed [31:0] total;
  logic               no_cruise;
} profile_sample_t;

class profile_scoreboard;
  localparam int FB = tvp_pkg::FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;

  logic [30:0]        accel, peak;
  logic signed [31:0] v_start, v_end, seg_len;
  longint             t_up, t_cruise, t_down;
  profile_sample_t    pending[$];
  int                 errors;

  function new();
    accel   = 31'(ONE);
    peak    = 31'(5 << (FB - 1));
    v_start = 0;
    v_end   = 0;
    seg_len = 0;
    t_up = 0; t_cruise = 0; t_down = 0;
    errors = 0;
  endfunction

  function automatic longint clip32(logic signed [95:0] v);
    if (v > 96'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -96'sh8000_0000) return -64'sh8000_0000;
    return longint'(v);
  endfunction

  function automatic longint ramp_dist(longint v0, longint v, longint t);
    logic signed [95:0] p;
    p = v0 + v;
    p = p * t;
    return clip32(p >>> (FB + 1));
  endfunction

  function void update_durations();
    longint a, v, d_up, d_down, d_cruise;
    a = (accel == 0) ? 1 : longint'(accel);
    v = (peak == 0) ? 1 : longint'(peak);
    t_up     = clip32(((v - longint'(v_start)) * ONE) / a);
    d_up     = ramp_dist(longint'(v_start), v, t_up);
    t_down   = clip32(((v - longint'(v_end)) * ONE) / a);
    d_down   = ramp_dist(longint'(v_end), v, t_down);
    d_cruise = clip32(longint'(seg_len) - (d_up + d_down));
    t_cruise = clip32((d_cruise * ONE) / v);
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] d);
    case (idx)
      tvp_pkg::REG_ACCEL: accel = d[30:0];
      tvp_pkg::REG_PEAK:  peak = d[30:0];
      tvp_pkg::REG_START: v_start = d;
      tvp_pkg::REG_END:   v_end = d;
      tvp_pkg::REG_LEN:   seg_len = d;
      default: return;
    endcase
    update_durations();
  endfunction

  function void note_request(logic signed [31:0] tn, logic signed [31:0] tb);
    longint a, e, total;
    logic signed [95:0] w;
    profile_sample_t s;
    a = (accel == 0) ? 1 : longint'(accel);
    e = longint'(tn) - longint'(tb);
    total = t_up + t_cruise + t_down;
    if (e < t_up) begin
      s.ph = tvp_pkg::PH_ACCEL;
      w = a;
      w = (w * e) >>> FB;
      s.speed = 32'(clip32(w + v_start));
    end else if (e > t_up + t_cruise) begin
      s.ph = tvp_pkg::PH_DECEL;
      w = a;
      w = (w * (total - e)) >>> FB;
      s.speed = 32'(clip32(w + v_end));
    end else begin
      s.ph = tvp_pkg::PH_CRUISE;
      s.speed = (peak == 0) ? 32'sd1 : 32'(peak);
    end
    s.total = 32'(clip32(total));
    s.no_cruise = (t_cruise < 0);
    pending = {pending, s};
  endfunction

  function void check_result(logic [71:0] d);
    profile_sample_t s;
    if (pending.size() == 0) begin
      $error("unexpected result %h", d);
      errors++;
      return;
    end
    s = pending.pop_front();
    if (d[31:0] !== s.speed) begin
      $error("speed_cmd exp %0d got %0d", s.speed, $signed(d[31:0]));
      errors++;
    end
    if (d[33:32] !== s.ph) begin
      $error("phase exp %0d got %0d", s.ph, d[33:32]);
      errors++;
    end
    if (d[65:34] !== s.total) begin
      $error("total_time exp %0d got %0d", s.total, $signed(d[65:34]));
      errors++;
    end
    if (d[66] !== s.no_cruise) begin
      $error("no_cruise exp %0d got %0d", s.no_cruise, d[66]);
      errors++;
    end
  endfunction
endclass

module trapezoidal_velocity_profile_tb;
  import tvp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 3'd5;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [63:0]          in_tdata = '0;   // time_now[31:0], time_begin[63:32]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [71:0]          out_tdata;       // speed_cmd[31:0], phase[33:32],
                                         // total_time[65:34], no_cruise[66]
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  profile_scoreboard sb = new();

  trapezoidal_velocity_profile u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_sample(logic [31:0] tn, logic [31:0] tb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {tb, tn};
    do @(posedge clk); while (!in_tready);
    sb.note_request(tn, tb);
  endtask

  task automatic send_elapsed(longint e);
    logic [31:0] tb;
    tb = $urandom_range(2 << 20) - (1 << 20);
    send_sample(32'(longint'($signed(tb)) + e), tb);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic load_profile(logic [31:0] a, logic [31:0] p, logic [31:0] s,
                              logic [31:0] e, logic [31:0] l);
    write_reg(REG_ACCEL, a);
    write_reg(REG_PEAK, p);
    write_reg(REG_START, s);
    write_reg(REG_END, e);
    write_reg(REG_LEN, l);
  endtask

  task automatic random_sample();
    longint total, e;
    total = sb.t_up + sb.t_cruise + sb.t_down;
    case ($urandom_range(4))
      0: send_sample($urandom, $urandom);
      1: send_elapsed(sb.t_up + $urandom_range(8) - 4);
      2: send_elapsed(sb.t_up + sb.t_cruise + $urandom_range(8) - 4);
      default: begin
        if (total > 0) e = ((longint'($urandom) * (total + 131072)) >>> 32) - 65536;
        else e = longint'($urandom_range(1 << 18)) - (1 << 17);
        send_elapsed(e);
      end
    endcase
  endtask

  task automatic boundary_samples();
    send_elapsed(-1);
    send_elapsed(0);
    send_elapsed(sb.t_up);
    send_elapsed(sb.t_up + sb.t_cruise + 1);
  endtask

  function automatic logic [31:0] rand_speed();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(1 << 20)) - (1 << 19);
      default: return $urandom_range(1 << 19);
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // durations still zero after reset
    boundary_samples();
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    for (int k = 0; k < 3; k++) write_reg(CFG_IDX_W'(IDX_SPARE + k), $urandom);

    load_profile(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    boundary_samples();
    drain();
    load_profile(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF);
    boundary_samples();
    drain();
    load_profile(32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    boundary_samples();
    drain();
    // too short for a cruise phase
    load_profile(32'h0001_0000, 32'h0002_8000, 32'h0, 32'h0, 32'h0000_8000);
    boundary_samples();
    send_sample(32'hFFFF_FFFF, 32'h0);
    drain();

    for (int ph = 0; ph < 32; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if ($urandom_range(7) == 0) begin
        load_profile($urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        load_profile($urandom_range(1 << 20, 1), $urandom_range(1 << 19, 1),
                     rand_speed(), rand_speed(), $urandom_range(1 << 24));
      end
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_IDX_W'(IDX_SPARE + $urandom_range(2)), $urandom);
      end
      for (int i = 0; i < 45; i++) begin
        random_sample();
        if (ph == 5 && i % 9 == 0) drain();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
